>>> rtl/core/rtpcls_pkg.sv
`default_nettype none

package rtpcls_pkg;

   // stream channel widths
   localparam int DATA_WIDTH       = 8;
   localparam int POS_WIDTH        = 7;
   localparam int OFS_WIDTH        = 8;
   localparam int VERDICT_WIDTH    = 4;
   localparam int KIND_WIDTH       = 3;
   localparam int NAL_WIDTH        = 5;
   localparam int PORT_WIDTH       = 16;
   localparam int HDR_BYTES_WIDTH  = 6;
   localparam int IP_ADDR_WIDTH    = 32;

   // configuration channel
   localparam int CSR_INDEX_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH   = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_DEST_IP   = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_DEST_PORT = 4'd1;

   localparam logic [IP_ADDR_WIDTH-1:0] TARGET_DEST_IP_RESET   = 32'h0A00_0002;
   localparam logic [PORT_WIDTH-1:0]    TARGET_DEST_PORT_RESET = 16'd5004;

   // frame layout
   localparam logic [POS_WIDTH-1:0] POS_MAX          = 7'd127;
   localparam logic [OFS_WIDTH-1:0] ETH_LEN          = 8'd14;
   localparam logic [OFS_WIDTH-1:0] IP_MIN_LEN       = 8'd20;
   localparam logic [OFS_WIDTH-1:0] UDP_LEN          = 8'd8;
   localparam logic [OFS_WIDTH-1:0] RTP_LEN          = 8'd12;
   localparam logic [OFS_WIDTH-1:0] OFS_ETHERTYPE_HI = 8'd12;
   localparam logic [OFS_WIDTH-1:0] OFS_ETHERTYPE_LO = 8'd13;
   localparam logic [OFS_WIDTH-1:0] OFS_IHL          = 8'd14;
   localparam logic [OFS_WIDTH-1:0] OFS_PROTOCOL     = 8'd23;
   localparam logic [OFS_WIDTH-1:0] OFS_DEST_FIRST   = 8'd30;
   localparam logic [OFS_WIDTH-1:0] OFS_DEST_LAST    = 8'd33;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [1:0]  RTP_VERSION    = 2'd2;

   // verdict codes
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_SHORT_ETH     = 4'd0;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_NOT_IPV4      = 4'd1;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_SHORT_IP      = 4'd2;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_WRONG_IP      = 4'd3;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_BAD_IHL       = 4'd4;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_SHORT_OPTIONS = 4'd5;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_NOT_UDP       = 4'd6;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_SHORT_UDP     = 4'd7;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_WRONG_PORT    = 4'd8;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_SHORT_RTP     = 4'd9;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_NOT_V2        = 4'd10;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_SHORT_PAYLOAD = 4'd11;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_CLASSIFIED    = 4'd12;

   // frame kinds
   localparam logic [KIND_WIDTH-1:0] KIND_OTHER      = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_IDR        = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_NON_IDR    = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_SPS        = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_PPS        = 3'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_FU_IDR     = 3'd5;
   localparam logic [KIND_WIDTH-1:0] KIND_FU_NON_IDR = 3'd6;

   // nal unit types
   localparam logic [NAL_WIDTH-1:0] NAL_NON_IDR = 5'd1;
   localparam logic [NAL_WIDTH-1:0] NAL_IDR     = 5'd5;
   localparam logic [NAL_WIDTH-1:0] NAL_SPS     = 5'd7;
   localparam logic [NAL_WIDTH-1:0] NAL_PPS     = 5'd8;
   localparam logic [NAL_WIDTH-1:0] NAL_FU_A    = 5'd28;

endpackage

`default_nettype wire

>>> rtl/core/rtpcls_req_if.sv
`default_nettype none

interface rtpcls_req_if
   import rtpcls_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] data_byte;
   logic                  last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rtpcls_rsp_if.sv
`default_nettype none

interface rtpcls_rsp_if
   import rtpcls_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [VERDICT_WIDTH-1:0]   verdict;
   logic [KIND_WIDTH-1:0]      frame_kind;
   logic [NAL_WIDTH-1:0]       nal_type;
   logic                       fu_start;
   logic                       fu_end;
   logic [NAL_WIDTH-1:0]       fu_original_type;
   logic [PORT_WIDTH-1:0]      source_port;
   logic [HDR_BYTES_WIDTH-1:0] ip_header_bytes;

   modport source (
      output valid, output verdict, output frame_kind, output nal_type,
      output fu_start, output fu_end, output fu_original_type,
      output source_port, output ip_header_bytes, input ready
   );
   modport sink (
      input valid, input verdict, input frame_kind, input nal_type,
      input fu_start, input fu_end, input fu_original_type,
      input source_port, input ip_header_bytes, output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/rtpcls_csr_if.sv
`default_nettype none

interface rtpcls_csr_if
   import rtpcls_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rtp_h264_packet_classifier.sv
// Classifies Ethernet/IPv4/UDP/RTP frames carrying H.264. Frame bytes enter on req_chan one
// byte per cycle, starting at the destination MAC, with last_byte on the final byte. The
// block takes a byte in every cycle in which rsp_chan is not stalled with a pending result;
// one result word appears on rsp_chan in the cycle after the last byte is accepted and sits
// in the output register until taken; the next frame's bytes wait meanwhile. The verdict
// checks EtherType, destination IP, IHL, protocol, destination port and RTP version in that
// order, with length checks in between; frame_kind and the FU-A fields are meaningful only
// for a classified frame. Offsets past 127 bytes are not tracked. csr_chan is always ready;
// write target_dest_ip at index 0 and target_dest_port at index 1 while no frame is open.
`default_nettype none

module rtp_h264_packet_classifier
   import rtpcls_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   rtpcls_req_if.sink  req_chan,
   rtpcls_rsp_if.source rsp_chan,
   rtpcls_csr_if.sink  csr_chan
);

   // configuration
   logic [IP_ADDR_WIDTH-1:0] target_ip_ff;
   logic [PORT_WIDTH-1:0]    target_port_ff;

   // frame capture state
   logic [POS_WIDTH-1:0]  pos_ff,         pos_in;
   logic [15:0]           ether_type_ff,  ether_type_in;
   logic [3:0]            header_words_ff, header_words_in;
   logic [7:0]            ip_protocol_ff, ip_protocol_in;
   logic [31:0]           dest_address_ff, dest_address_in;
   logic [15:0]           src_port_ff,    src_port_in;
   logic [15:0]           dst_port_ff,    dst_port_in;
   logic [7:0]            rtp_first_ff,   rtp_first_in;
   logic [15:0]           payload_head_ff, payload_head_in;

   // result register
   logic                       rsp_valid_ff,  rsp_valid_in;
   logic [VERDICT_WIDTH-1:0]   verdict_ff,    verdict_in;
   logic [KIND_WIDTH-1:0]      kind_ff,       kind_in;
   logic [NAL_WIDTH-1:0]       nal_ff,        nal_in;
   logic                       fu_start_ff,   fu_start_in;
   logic                       fu_end_ff,     fu_end_in;
   logic [NAL_WIDTH-1:0]       fu_orig_ff,    fu_orig_in;
   logic [PORT_WIDTH-1:0]      src_out_ff,    src_out_in;
   logic [HDR_BYTES_WIDTH-1:0] hdr_bytes_ff,  hdr_bytes_in;

   logic                  accept;
   logic                  load_result;
   logic [OFS_WIDTH-1:0]  pos8;
   logic [OFS_WIDTH-1:0]  base;
   logic [OFS_WIDTH-1:0]  frame_len;
   logic [OFS_WIDTH-1:0]  hl;
   logic [DATA_WIDTH-1:0] b;
   logic [NAL_WIDTH-1:0]  first_nal;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign load_result    = accept && req_chan.last_byte;
   assign csr_chan.ready = 1'b1;

   assign b    = req_chan.data_byte;
   assign pos8 = {1'b0, pos_ff};
   // udp offset follows the ihl held before this byte
   assign base = ETH_LEN + {2'b00, header_words_ff, 2'b00};

   // field capture
   always_comb begin
      ether_type_in   = ether_type_ff;
      header_words_in = header_words_ff;
      ip_protocol_in  = ip_protocol_ff;
      dest_address_in = dest_address_ff;
      src_port_in     = src_port_ff;
      dst_port_in     = dst_port_ff;
      rtp_first_in    = rtp_first_ff;
      payload_head_in = payload_head_ff;
      if (pos8 == OFS_ETHERTYPE_HI) ether_type_in[15:8] = b;
      if (pos8 == OFS_ETHERTYPE_LO) ether_type_in[7:0]  = b;
      if (pos8 == OFS_IHL)          header_words_in     = b[3:0];
      if (pos8 == OFS_PROTOCOL)     ip_protocol_in      = b;
      if (pos8 >= OFS_DEST_FIRST && pos8 <= OFS_DEST_LAST) begin
         dest_address_in = {dest_address_ff[23:0], b};
      end
      if (pos8 == base)                  src_port_in[15:8] = b;
      if (pos8 == base + 8'd1)           src_port_in[7:0]  = b;
      if (pos8 == base + 8'd2)           dst_port_in[15:8] = b;
      if (pos8 == base + 8'd3)           dst_port_in[7:0]  = b;
      if (pos8 == base + UDP_LEN)        rtp_first_in      = b;
      if (pos8 == base + UDP_LEN + RTP_LEN) begin
         payload_head_in[15:8] = b;
      end
      if (pos8 == base + UDP_LEN + RTP_LEN + 8'd1) begin
         payload_head_in[7:0] = b;
      end
   end

   assign pos_in    = (pos_ff < POS_MAX) ? pos_ff + 7'd1 : pos_ff;
   assign frame_len = pos8 + 8'd1;
   assign hl        = {2'b00, header_words_in, 2'b00};
   assign first_nal = payload_head_in[12:8];

   // verdict and nal classification on the updated captures
   always_comb begin
      if (frame_len < ETH_LEN) begin
         verdict_in = VERDICT_SHORT_ETH;
      end else if (ether_type_in != ETHERTYPE_IPV4) begin
         verdict_in = VERDICT_NOT_IPV4;
      end else if (frame_len < ETH_LEN + IP_MIN_LEN) begin
         verdict_in = VERDICT_SHORT_IP;
      end else if (dest_address_in != target_ip_ff) begin
         verdict_in = VERDICT_WRONG_IP;
      end else if (hl < IP_MIN_LEN) begin
         verdict_in = VERDICT_BAD_IHL;
      end else if (frame_len < ETH_LEN + hl) begin
         verdict_in = VERDICT_SHORT_OPTIONS;
      end else if (ip_protocol_in != PROTO_UDP) begin
         verdict_in = VERDICT_NOT_UDP;
      end else if (frame_len < ETH_LEN + hl + UDP_LEN) begin
         verdict_in = VERDICT_SHORT_UDP;
      end else if (dst_port_in != target_port_ff) begin
         verdict_in = VERDICT_WRONG_PORT;
      end else if (frame_len < ETH_LEN + hl + UDP_LEN + RTP_LEN) begin
         verdict_in = VERDICT_SHORT_RTP;
      end else if (rtp_first_in[7:6] != RTP_VERSION) begin
         verdict_in = VERDICT_NOT_V2;
      end else if (frame_len < ETH_LEN + hl + UDP_LEN + RTP_LEN + 8'd2) begin
         verdict_in = VERDICT_SHORT_PAYLOAD;
      end else begin
         verdict_in = VERDICT_CLASSIFIED;
      end

      kind_in     = KIND_OTHER;
      nal_in      = '0;
      fu_start_in = 1'b0;
      fu_end_in   = 1'b0;
      fu_orig_in  = '0;
      if (verdict_in == VERDICT_CLASSIFIED) begin
         nal_in = first_nal;
         unique case (first_nal)
            NAL_IDR:     kind_in = KIND_IDR;
            NAL_NON_IDR: kind_in = KIND_NON_IDR;
            NAL_SPS:     kind_in = KIND_SPS;
            NAL_PPS:     kind_in = KIND_PPS;
            NAL_FU_A: begin
               fu_orig_in  = payload_head_in[4:0];
               fu_start_in = payload_head_in[7];
               fu_end_in   = payload_head_in[6];
               kind_in     = (payload_head_in[4:0] == NAL_IDR) ? KIND_FU_IDR
                                                                : KIND_FU_NON_IDR;
            end
            default:     kind_in = KIND_OTHER;
         endcase
      end

      src_out_in   = (verdict_in >= VERDICT_WRONG_PORT) ? src_port_in : '0;
      hdr_bytes_in = (verdict_in >= VERDICT_BAD_IHL) ? {header_words_in, 2'b00} : '0;
   end

   always_comb begin
      if (load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ip_ff   <= TARGET_DEST_IP_RESET;
         target_port_ff <= TARGET_DEST_PORT_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_TARGET_DEST_IP:   target_ip_ff   <= csr_chan.data;
            CSR_TARGET_DEST_PORT: target_port_ff <= csr_chan.data[PORT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || load_result) begin
         // captures start over after each frame
         pos_ff          <= '0;
         ether_type_ff   <= '0;
         header_words_ff <= '0;
         ip_protocol_ff  <= '0;
         dest_address_ff <= '0;
         src_port_ff     <= '0;
         dst_port_ff     <= '0;
         rtp_first_ff    <= '0;
         payload_head_ff <= '0;
      end else if (accept) begin
         pos_ff          <= pos_in;
         ether_type_ff   <= ether_type_in;
         header_words_ff <= header_words_in;
         ip_protocol_ff  <= ip_protocol_in;
         dest_address_ff <= dest_address_in;
         src_port_ff     <= src_port_in;
         dst_port_ff     <= dst_port_in;
         rtp_first_ff    <= rtp_first_in;
         payload_head_ff <= payload_head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_result) begin
         verdict_ff   <= verdict_in;
         kind_ff      <= kind_in;
         nal_ff       <= nal_in;
         fu_start_ff  <= fu_start_in;
         fu_end_ff    <= fu_end_in;
         fu_orig_ff   <= fu_orig_in;
         src_out_ff   <= src_out_in;
         hdr_bytes_ff <= hdr_bytes_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.verdict          = verdict_ff;
   assign rsp_chan.frame_kind       = kind_ff;
   assign rsp_chan.nal_type         = nal_ff;
   assign rsp_chan.fu_start         = fu_start_ff;
   assign rsp_chan.fu_end           = fu_end_ff;
   assign rsp_chan.fu_original_type = fu_orig_ff;
   assign rsp_chan.source_port      = src_out_ff;
   assign rsp_chan.ip_header_bytes  = hdr_bytes_ff;

endmodule

`default_nettype wire

>>> rtl/core/rtpcls_checker.sv
`default_nettype none

module rtpcls_checker
   import rtpcls_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     req_last_byte,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [VERDICT_WIDTH-1:0] rsp_verdict,
   input wire logic [KIND_WIDTH-1:0]    rsp_frame_kind,
   input wire logic [NAL_WIDTH-1:0]     rsp_nal_type
);

   // a pending result is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a new result only follows an accepted last byte
   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_byte))
      else $error("result word without a frame end");

   a_kind_only_classified: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != VERDICT_CLASSIFIED
         |-> rsp_frame_kind == KIND_OTHER && rsp_nal_type == '0)
      else $error("nal fields set on an unclassified frame");

endmodule

bind rtp_h264_packet_classifier rtpcls_checker u_rtpcls_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_last_byte  (req_chan.last_byte),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_verdict    (rsp_chan.verdict),
   .rsp_frame_kind (rsp_chan.frame_kind),
   .rsp_nal_type   (rsp_chan.nal_type)
);

`default_nettype wire
